/* sv/qau_pkg.sv */
package qau_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned CompW     = 32;
  localparam int unsigned ProdW     = 2 * CompW;
  // four products of magnitude up to 2^62 need two guard bits
  localparam int unsigned SumW      = ProdW + 2;

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0]  sum_t;

  typedef enum logic [1:0] {
    ActMul  = 2'd0,
    ActDiff = 2'd1,
    ActRot  = 2'd2
  } qau_action_e;

  typedef struct packed {
    logic  ovf;
    comp_t val;
  } rsat_t;

  localparam sum_t  RoundHalf = sum_t'(1) <<< (FRAC_BITS - 1);
  localparam comp_t CompMax   = {1'b0, {(CompW-1){1'b1}}};
  localparam comp_t CompMin   = {1'b1, {(CompW-1){1'b0}}};

  // sign-extend one product to sum width, optionally negated
  function automatic sum_t ext_term(input prod_t t, input logic neg);
    sum_t e;
    e = {{(SumW-ProdW){t[ProdW-1]}}, t};
    return neg ? -e : e;
  endfunction

  function automatic sum_t sum4(input prod_t t0, input prod_t t1, input prod_t t2,
                                input prod_t t3, input logic [0:3] neg);
    return ext_term(t0, neg[0]) + ext_term(t1, neg[1]) +
           ext_term(t2, neg[2]) + ext_term(t3, neg[3]);
  endfunction

  // round to nearest (ties up) and saturate to the component width
  function automatic rsat_t round_sat(input sum_t s);
    sum_t                          rs;
    logic [SumW-FRAC_BITS-1:0]     v;
    logic [SumW-FRAC_BITS-CompW:0] hi;
    rsat_t                         res;
    rs = s + RoundHalf;
    v  = rs[SumW-1:FRAC_BITS];
    hi = v[SumW-FRAC_BITS-1:CompW-1];
    if ((&hi) || !(|hi)) begin
      res.ovf = 1'b0;
      res.val = comp_t'(v[CompW-1:0]);
    end else begin
      res.ovf = 1'b1;
      res.val = v[SumW-FRAC_BITS-1] ? CompMin : CompMax;
    end
    return res;
  endfunction

endpackage

/* sv/quaternion_arithmetic_unit_core.sv */
// Every action takes the same path from an accepted start to the done_o strobe.
// Throughput: one transaction per cycle; busy_o stays low, the pipeline never stalls.
// Stages: products, sums, round/saturate, then a second product/sum/round pass that
// rotate uses and the other actions bypass; the 32x32 multiplier arrays set the pace.
// Reset clears the valid bits and the strobe; data registers are not reset.
// The receiver cannot stall: each result is shown for one cycle only.
module quaternion_arithmetic_unit_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          action_i,
  input  qau_pkg::comp_t      a_x_i,
  input  qau_pkg::comp_t      a_y_i,
  input  qau_pkg::comp_t      a_z_i,
  input  qau_pkg::comp_t      a_w_i,
  input  qau_pkg::comp_t      b_x_i,
  input  qau_pkg::comp_t      b_y_i,
  input  qau_pkg::comp_t      b_z_i,
  input  qau_pkg::comp_t      b_w_i,
  output logic                done_o,
  output qau_pkg::comp_t      r_x_o,
  output qau_pkg::comp_t      r_y_o,
  output qau_pkg::comp_t      r_z_o,
  output qau_pkg::comp_t      r_w_o,
  output logic                overflow_o
);
  import qau_pkg::*;

  logic  accept;
  comp_t a_in [4];
  comp_t b_in [4];

  // stage 1: a_i * b_j
  logic  v1_q;
  logic [1:0] act1_q;
  comp_t a1_q [4];
  prod_t p1_d [4][4];
  prod_t p1_q [4][4];

  // stage 2: signed sums
  logic  v2_q;
  logic [1:0] act2_q;
  comp_t a2_q [4];
  sum_t  s2_d [4];
  sum_t  s2_q [4];

  // stage 3: first rounded quaternion
  logic  v3_q;
  logic [1:0] act3_q;
  comp_t a3_q [4];
  rsat_t m3_d [4];
  comp_t m3_q [4];
  logic  ovf3_q;

  // stage 4: a_i * m_j
  logic  v4_q;
  logic [1:0] act4_q;
  comp_t m4_q [4];
  logic  ovf4_q;
  prod_t p4_d [4][4];
  prod_t p4_q [4][4];

  // stage 5: second sums, vector part only
  logic  v5_q;
  logic [1:0] act5_q;
  comp_t m5_q [4];
  logic  ovf5_q;
  sum_t  s5_d [3];
  sum_t  s5_q [3];

  // stage 6: output
  rsat_t r6_d [3];
  logic  done_q;
  comp_t r_q [4];
  logic  ovf_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign a_in[0] = a_x_i;
  assign a_in[1] = a_y_i;
  assign a_in[2] = a_z_i;
  assign a_in[3] = a_w_i;
  assign b_in[0] = b_x_i;
  assign b_in[1] = b_y_i;
  assign b_in[2] = b_z_i;
  assign b_in[3] = b_w_i;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p1_d[i][j] = a_in[i] * b_in[j];
        p4_d[i][j] = a3_q[i] * m3_q[j];
      end
    end
  end

  // map the shared products onto each action's signed sums
  always_comb begin
    case (act1_q)
      ActDiff: begin
        s2_d[0] = sum4(p1_q[3][0], p1_q[0][3], p1_q[1][2], p1_q[2][1], 4'b1010);
        s2_d[1] = sum4(p1_q[3][1], p1_q[0][2], p1_q[1][3], p1_q[2][0], 4'b1001);
        s2_d[2] = sum4(p1_q[3][2], p1_q[0][1], p1_q[1][0], p1_q[2][3], 4'b1100);
        s2_d[3] = sum4(p1_q[3][3], p1_q[0][0], p1_q[1][1], p1_q[2][2], 4'b0000);
      end
      ActRot: begin
        // vec * conj(A), with the vector's w taken as zero
        s2_d[0] = sum4(p1_q[3][0], p1_q[2][1], p1_q[1][2], '0, 4'b0100);
        s2_d[1] = sum4(p1_q[2][0], p1_q[3][1], p1_q[0][2], '0, 4'b0010);
        s2_d[2] = sum4(p1_q[1][0], p1_q[0][1], p1_q[3][2], '0, 4'b1000);
        s2_d[3] = sum4(p1_q[0][0], p1_q[1][1], p1_q[2][2], '0, 4'b0000);
      end
      default: begin
        s2_d[0] = sum4(p1_q[3][0], p1_q[0][3], p1_q[1][2], p1_q[2][1], 4'b0001);
        s2_d[1] = sum4(p1_q[3][1], p1_q[0][2], p1_q[1][3], p1_q[2][0], 4'b0100);
        s2_d[2] = sum4(p1_q[3][2], p1_q[0][1], p1_q[1][0], p1_q[2][3], 4'b0010);
        s2_d[3] = sum4(p1_q[3][3], p1_q[0][0], p1_q[1][1], p1_q[2][2], 4'b0111);
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      m3_d[i] = round_sat(s2_q[i]);
    end
    s5_d[0] = sum4(p4_q[3][0], p4_q[0][3], p4_q[1][2], p4_q[2][1], 4'b0001);
    s5_d[1] = sum4(p4_q[3][1], p4_q[0][2], p4_q[1][3], p4_q[2][0], 4'b0100);
    s5_d[2] = sum4(p4_q[3][2], p4_q[0][1], p4_q[1][0], p4_q[2][3], 4'b0010);
    for (int i = 0; i < 3; i++) begin
      r6_d[i] = round_sat(s5_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= accept;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      done_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    act1_q <= action_i;
    a1_q   <= a_in;
    p1_q   <= p1_d;

    act2_q <= act1_q;
    a2_q   <= a1_q;
    s2_q   <= s2_d;

    act3_q <= act2_q;
    a3_q   <= a2_q;
    for (int i = 0; i < 4; i++) begin
      m3_q[i] <= m3_d[i].val;
    end
    ovf3_q <= m3_d[0].ovf | m3_d[1].ovf | m3_d[2].ovf | m3_d[3].ovf;

    act4_q <= act3_q;
    m4_q   <= m3_q;
    ovf4_q <= ovf3_q;
    p4_q   <= p4_d;

    act5_q <= act4_q;
    m5_q   <= m4_q;
    ovf5_q <= ovf4_q;
    s5_q   <= s5_d;

    // rotate takes the second pass; other actions bypass it
    if (act5_q == ActRot) begin
      r_q[0] <= r6_d[0].val;
      r_q[1] <= r6_d[1].val;
      r_q[2] <= r6_d[2].val;
      r_q[3] <= '0;
      ovf_q  <= ovf5_q | r6_d[0].ovf | r6_d[1].ovf | r6_d[2].ovf;
    end else begin
      r_q   <= m5_q;
      ovf_q <= ovf5_q;
    end
  end

  assign done_o     = done_q;
  assign r_x_o      = r_q[0];
  assign r_y_o      = r_q[1];
  assign r_z_o      = r_q[2];
  assign r_w_o      = r_q[3];
  assign overflow_o = ovf_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##6 done_o)
    else $error("accepted transaction did not complete after six cycles");

  a_rot_w_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i == ActRot) |-> ##6 (r_w_o == '0))
    else $error("rotate result has nonzero w");

  a_ovf_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && ovf3_q) |-> ##3 (done_o && overflow_o))
    else $error("first-pass saturation lost before output");

endmodule
